@@ rtl/lmrr_pkg.sv @@
package lmrr_pkg;

  localparam int DEF_NUM_LOCKS   = 16;
  localparam int DEF_QUEUE_DEPTH = 8;

  localparam int FUNC_W   = 1;
  localparam int LOCK_W   = 4;
  localparam int CLIENT_W = 3;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ACQUIRE = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    LK_FREE     = 2'd0,
    LK_LOCKED   = 2'd1,
    LK_WAITERS  = 2'd2,
    LK_RETRYING = 2'd3
  } lock_st_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK    = 2'd0,
    RES_RETRY = 2'd1,
    RES_IOERR = 2'd2,
    RES_FULL  = 2'd3
  } res_t;

  typedef enum logic [KIND_W-1:0] {
    MSG_NONE   = 2'd0,
    MSG_REVOKE = 2'd1,
    MSG_RETRY  = 2'd2
  } msg_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EXEC
  } lmrr_state_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic look;
    logic exec;
  } lmrr_cmd_t;

  typedef struct packed {
    logic clr_last;
  } lmrr_sts_t;

endpackage

@@ rtl/lmrr_ram.sv @@
module lmrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lmrr_ctrl.sv @@
module lmrr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lmrr_pkg::lmrr_sts_t sts,
  output logic                busy,
  output lmrr_pkg::lmrr_cmd_t cmd
);
  import lmrr_pkg::*;

  lmrr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_LOOK:  cmd.look = 1'b1;
      S_EXEC:  cmd.exec = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/lmrr_dp.sv @@
module lmrr_dp #(
  parameter int NUM_LOCKS   = lmrr_pkg::DEF_NUM_LOCKS,
  parameter int QUEUE_DEPTH = lmrr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lmrr_pkg::lmrr_cmd_t           cmd,
  output lmrr_pkg::lmrr_sts_t           sts,
  input  logic [lmrr_pkg::FUNC_W-1:0]   in_func,
  input  logic [lmrr_pkg::LOCK_W-1:0]   in_lock_num,
  input  logic [lmrr_pkg::CLIENT_W-1:0] in_client_num,
  output logic                          out_valid,
  output logic [lmrr_pkg::STATUS_W-1:0] out_status,
  output logic [lmrr_pkg::KIND_W-1:0]   out_notify_kind,
  output logic [lmrr_pkg::CLIENT_W-1:0] out_notify_client
);
  import lmrr_pkg::*;

  localparam int LW  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int XW  = ((LW > LOCK_W) ? LW : LOCK_W) + 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = CW + 1;
  localparam int EW  = 2 + CLIENT_W + QW + CW;
  localparam int WAW = LW + QW;

  // lock entry layout: {state, owner, head, count}
  localparam int CNT_LO = 0;
  localparam int HD_LO  = CW;
  localparam int OWN_LO = CW + QW;
  localparam int ST_LO  = CW + QW + CLIENT_W;

  logic [LW-1:0]       clr_cnt_r;
  logic [FUNC_W-1:0]   func_r;
  logic [LW-1:0]       lk_r;
  logic                inr_r;
  logic [CLIENT_W-1:0] cli_r;
  logic [EW-1:0]       ent_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r,  out_status_nxt;
  logic [KIND_W-1:0]   out_kind_r,    out_kind_nxt;
  logic [CLIENT_W-1:0] out_client_r,  out_client_nxt;

  logic [XW-1:0]       lk_x;
  logic                in_range;

  logic                lt_we;
  logic [LW-1:0]       lt_waddr;
  logic [EW-1:0]       lt_wdata;
  logic [EW-1:0]       lt_rdata;

  logic                wq_we;
  logic [WAW-1:0]      wq_waddr;
  logic [WAW-1:0]      wq_raddr;
  logic [CLIENT_W-1:0] wq_rdata;

  lock_st_t            st;
  logic [CLIENT_W-1:0] owner;
  logic [QW-1:0]       head;
  logic [CW-1:0]       cnt;
  logic                full, empty, head_hit;
  logic [PW-1:0]       sum;
  logic [QW-1:0]       push_pos;
  logic [QW-1:0]       head_inc;
  logic [CW-1:0]       cnt_dec;

  lock_st_t            st_new;
  logic [CLIENT_W-1:0] owner_new;
  logic [QW-1:0]       head_new;
  logic [CW-1:0]       cnt_new;
  logic                upd, push;

  assign lk_x     = XW'(in_lock_num);
  assign in_range = lk_x < XW'(NUM_LOCKS);

  assign sts.clr_last = clr_cnt_r == LW'(NUM_LOCKS - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + LW'(1);
      out_valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      lk_r   <= lk_x[LW-1:0];
      inr_r  <= in_range;
      cli_r  <= in_client_num;
    end
    if (cmd.look) ent_r <= lt_rdata;
    if (cmd.exec) begin
      out_status_r <= out_status_nxt;
      out_kind_r   <= out_kind_nxt;
      out_client_r <= out_client_nxt;
    end
  end

  // queue head slot is read with the entry's head straight from the table output
  assign wq_raddr = {lk_r, lt_rdata[HD_LO +: QW]};

  assign st       = lock_st_t'(ent_r[ST_LO +: 2]);
  assign owner    = ent_r[OWN_LO +: CLIENT_W];
  assign head     = ent_r[HD_LO +: QW];
  assign cnt      = ent_r[CNT_LO +: CW];
  assign full     = cnt == CW'(QUEUE_DEPTH);
  assign empty    = cnt == '0;
  assign head_hit = wq_rdata == cli_r;
  assign cnt_dec  = cnt - CW'(1);
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);

  // head < depth and count < depth on a push, so one subtract wraps it
  always_comb begin
    sum = PW'(head) + PW'(cnt);
    if (sum >= PW'(QUEUE_DEPTH)) sum = sum - PW'(QUEUE_DEPTH);
    push_pos = sum[QW-1:0];
  end

  always_comb begin
    st_new         = st;
    owner_new      = owner;
    head_new       = head;
    cnt_new        = cnt;
    upd            = 1'b0;
    push           = 1'b0;
    out_status_nxt = RES_OK;
    out_kind_nxt   = MSG_NONE;
    out_client_nxt = '0;
    if (!inr_r) begin
      out_status_nxt = RES_IOERR;
    end else if (func_r == FUNC_ACQUIRE) begin
      case (st)
        LK_FREE: begin
          upd       = 1'b1;
          st_new    = LK_LOCKED;
          owner_new = cli_r;
        end
        LK_RETRYING: begin
          if (empty) begin
            upd       = 1'b1;
            st_new    = LK_LOCKED;
            owner_new = cli_r;
          end else if (head_hit) begin
            upd       = 1'b1;
            head_new  = head_inc;
            cnt_new   = cnt_dec;
            owner_new = cli_r;
            if (cnt_dec != '0) begin
              st_new         = LK_WAITERS;
              out_kind_nxt   = MSG_REVOKE;
              out_client_nxt = cli_r;
            end else begin
              st_new = LK_LOCKED;
            end
          end else if (full) begin
            out_status_nxt = RES_FULL;
          end else begin
            upd            = 1'b1;
            push           = 1'b1;
            cnt_new        = cnt + CW'(1);
            out_status_nxt = RES_RETRY;
          end
        end
        default: begin
          if (full) begin
            out_status_nxt = RES_FULL;
          end else begin
            upd            = 1'b1;
            push           = 1'b1;
            cnt_new        = cnt + CW'(1);
            st_new         = LK_WAITERS;
            out_status_nxt = RES_RETRY;
            out_kind_nxt   = MSG_REVOKE;
            out_client_nxt = owner;
          end
        end
      endcase
    end else begin
      case (st)
        LK_LOCKED: begin
          upd       = 1'b1;
          st_new    = LK_FREE;
          owner_new = '0;
        end
        LK_WAITERS: begin
          upd       = 1'b1;
          owner_new = '0;
          if (!empty) begin
            st_new         = LK_RETRYING;
            out_kind_nxt   = MSG_RETRY;
            out_client_nxt = wq_rdata;
          end else begin
            st_new = LK_FREE;
          end
        end
        default: out_status_nxt = RES_IOERR;
      endcase
    end
  end

  always_comb begin
    if (cmd.clear) begin
      lt_we    = 1'b1;
      lt_waddr = clr_cnt_r;
      lt_wdata = '0;
    end else begin
      lt_we    = cmd.exec & upd;
      lt_waddr = lk_r;
      lt_wdata = {st_new, owner_new, head_new, cnt_new};
    end
  end

  assign wq_we    = cmd.exec & push;
  assign wq_waddr = {lk_r, push_pos};

  lmrr_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_LOCKS)
  ) u_lock_tbl (
    .clk   (clk),
    .we    (lt_we),
    .waddr (lt_waddr),
    .wdata (lt_wdata),
    .re    (cmd.accept),
    .raddr (lk_x[LW-1:0]),
    .rdata (lt_rdata)
  );

  lmrr_ram #(
    .WIDTH (CLIENT_W),
    .DEPTH ((2 ** LW) * (2 ** QW))
  ) u_wait_q (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (cli_r),
    .re    (cmd.look),
    .raddr (wq_raddr),
    .rdata (wq_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_notify_kind   = out_kind_r;
  assign out_notify_client = out_client_r;

endmodule

@@ rtl/lock_manager_revoke_retry.sv @@
// Channel   Ports                                          Handshake
// input     in_func, in_lock_num, in_client_num            start & !busy
// result    out_status, out_notify_kind, out_notify_client out_valid strobe, one cycle
//
// Each beat steps through lock table read, queue head read, then update and
// result. The result is registered and shows in the cycle after the update,
// while the next beat may already be taken. The two chained synchronous
// reads set the rate. After reset a clearing pass writes every lock entry
// free, with busy high. The receiver cannot stall; out_valid lasts one cycle.
module lock_manager_revoke_retry #(
  parameter int NUM_LOCKS   = lmrr_pkg::DEF_NUM_LOCKS,
  parameter int QUEUE_DEPTH = lmrr_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lmrr_pkg::FUNC_W-1:0]   in_func,
  input  logic [lmrr_pkg::LOCK_W-1:0]   in_lock_num,
  input  logic [lmrr_pkg::CLIENT_W-1:0] in_client_num,
  output logic                          out_valid,
  output logic [lmrr_pkg::STATUS_W-1:0] out_status,
  output logic [lmrr_pkg::KIND_W-1:0]   out_notify_kind,
  output logic [lmrr_pkg::CLIENT_W-1:0] out_notify_client
);
  import lmrr_pkg::*;

  lmrr_cmd_t cmd;
  lmrr_sts_t sts;

  lmrr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  lmrr_dp #(
    .NUM_LOCKS   (NUM_LOCKS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_lock_num       (in_lock_num),
    .in_client_num     (in_client_num),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_notify_kind   (out_notify_kind),
    .out_notify_client (out_notify_client)
  );

endmodule
